[rtl/sprite_shift_or_blitter_assert.svh]
// Assertion macros for the blitter RTL.
`ifndef SPRITE_SHIFT_OR_BLITTER_ASSERT_SVH
`define SPRITE_SHIFT_OR_BLITTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sprite_shift_or_blitter: assertion failed");

// Next-cycle implication, checked outside reset.
`define SBL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sprite_shift_or_blitter: assertion failed");

`endif

[rtl/sbl_pkg.sv]
// Shared types and constants of the monochrome sprite blitter.
package sbl_pkg;

    localparam int SCREEN_W_DEF  = 640;
    localparam int SCREEN_H_DEF  = 400;
    localparam int ROW_BYTES_DEF = 80;
    localparam int SPRITE_H_DEF  = 32;
    localparam int HITBOX_W_DEF  = 64;

    localparam int WORD_BITS  = 32;
    localparam int GLYPH_BITS = 8;
    localparam int GLYPH_ROWS = 8;
    localparam int MAX_WRITES = 3;

    localparam int ADDR_W     = 24;
    localparam int POS_W      = 11;
    localparam int ROWS_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [ROWS_W-1:0] SPRITE_ROWS_RST = 9'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_BASE  = 3'd0,
        REG_POS_X       = 3'd1,
        REG_POS_Y       = 3'd2,
        REG_BLIT_MODE   = 3'd3,
        REG_SPRITE_ROWS = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_W32   = 2'd0,
        MODE_W64   = 2'd1,
        MODE_GLYPH = 2'd2
    } blit_mode_t;

    typedef struct packed {
        logic [31:0] row_word_a;
        logic [31:0] row_word_b;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] write_addr;
        logic [31:0]       write_data;
        logic              byte_write;
        logic              last_write;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]       frame_base;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [1:0]              blit_mode;
        logic [ROWS_W-1:0]       sprite_rows;
        logic [ROWS_W-1:0]       row_count;
    } cfg_state_t;

    typedef struct packed {
        logic [1:0]                  count;
        out_item_t [MAX_WRITES-1:0]  wr;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [ROWS_W-1:0] value;
    } row_upd_t;

endpackage

[rtl/sbl_cfg.sv]
// Configuration registers and the bitmap row counter.
module sbl_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [sbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           item_accept,
    input  sbl_pkg::row_upd_t              upd,
    output sbl_pkg::cfg_state_t            state
);
    import sbl_pkg::*;

    cfg_state_t state_reg;
    cfg_state_t state_next;

    always_comb begin
        state_next = state_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_BASE: begin
                    state_next.frame_base = cfg_wdata[ADDR_W-1:0];
                    state_next.row_count  = '0;
                end
                REG_POS_X: begin
                    state_next.pos_x     = cfg_wdata[POS_W-1:0];
                    state_next.row_count = '0;
                end
                REG_POS_Y: begin
                    state_next.pos_y     = cfg_wdata[POS_W-1:0];
                    state_next.row_count = '0;
                end
                REG_BLIT_MODE: begin
                    state_next.blit_mode = cfg_wdata[1:0];
                    state_next.row_count = '0;
                end
                REG_SPRITE_ROWS: begin
                    state_next.sprite_rows = cfg_wdata[ROWS_W-1:0];
                    state_next.row_count   = '0;
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end else if (item_accept && upd.en) begin
            state_next.row_count = upd.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.frame_base  <= '0;
            state_reg.pos_x       <= '0;
            state_reg.pos_y       <= '0;
            state_reg.blit_mode   <= MODE_W32;
            state_reg.sprite_rows <= SPRITE_ROWS_RST;
            state_reg.row_count   <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

[rtl/sbl_calc.sv]
// Row addressing, clipping and shift logic that turns one row into its writes.
module sbl_calc #(
    parameter int SCREEN_W  = sbl_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H  = sbl_pkg::SCREEN_H_DEF,
    parameter int ROW_BYTES = sbl_pkg::ROW_BYTES_DEF,
    parameter int SPRITE_H  = sbl_pkg::SPRITE_H_DEF,
    parameter int HITBOX_W  = sbl_pkg::HITBOX_W_DEF
) (
    input  sbl_pkg::cfg_state_t cfg,
    input  sbl_pkg::in_item_t   item,
    output sbl_pkg::job_t       job,
    output sbl_pkg::row_upd_t   upd
);
    import sbl_pkg::*;

    localparam int RB_W   = $clog2(ROW_BYTES + 1);
    localparam int PROD_W = POS_W + RB_W;

    localparam logic signed [13:0] X32_MAX = 14'(SCREEN_W - WORD_BITS);
    localparam logic signed [13:0] Y32_MAX = 14'(SCREEN_H - SPRITE_H);
    localparam logic signed [13:0] X64_MAX = 14'(SCREEN_W - HITBOX_W);
    localparam logic signed [13:0] Y64_MAX = 14'(SCREEN_H);
    localparam logic signed [13:0] XG_LIM  = 14'(SCREEN_W - GLYPH_BITS);
    localparam logic signed [13:0] YG_LIM  = 14'(SCREEN_H - GLYPH_ROWS);

    logic signed [13:0] px;
    logic signed [13:0] py;
    logic signed [13:0] srow;
    logic signed [13:0] py_end;
    logic [PROD_W-1:0]  prod;
    logic [ADDR_W-1:0]  row_start;
    logic [ADDR_W-1:0]  word_addr;
    logic [ADDR_W-1:0]  byte_addr;
    logic [4:0]         sh;
    logic [2:0]         gsh;
    logic [31:0]        a_main;
    logic [31:0]        a_spill;
    logic [31:0]        b_main;
    logic [31:0]        b_spill;
    logic [7:0]         glyph;
    logic [7:0]         g_main;
    logic [7:0]         g_spill;
    logic [ROWS_W-1:0]  limit;
    logic [ROWS_W:0]    rc_inc;
    blit_mode_t         mode;

    always_comb begin
        px     = {{3{cfg.pos_x[POS_W-1]}}, cfg.pos_x};
        py     = {{3{cfg.pos_y[POS_W-1]}}, cfg.pos_y};
        srow   = py + $signed({5'd0, cfg.row_count});
        py_end = py + $signed({5'd0, cfg.sprite_rows});

        // Drawn rows never have a negative screen row, so 11 bits suffice.
        prod      = PROD_W'(srow[POS_W-1:0]) * PROD_W'(ROW_BYTES);
        row_start = cfg.frame_base + ADDR_W'(prod);
        word_addr = row_start + {16'd0, px[10:5], 2'b00};
        byte_addr = row_start + {16'd0, px[10:3]};

        sh      = px[4:0];
        a_main  = item.row_word_a >> sh;
        b_main  = item.row_word_b >> sh;
        a_spill = (sh == 5'd0) ? 32'd0 : (item.row_word_a << (5'd0 - sh));
        b_spill = (sh == 5'd0) ? 32'd0 : (item.row_word_b << (5'd0 - sh));

        gsh     = px[2:0];
        glyph   = item.row_word_a[7:0];
        g_main  = glyph >> gsh;
        g_spill = (gsh == 3'd0) ? 8'd0 : (glyph << (3'd0 - gsh));

        mode = blit_mode_t'(cfg.blit_mode);

        limit  = (mode == MODE_GLYPH) ? ROWS_W'(GLYPH_ROWS) : cfg.sprite_rows;
        rc_inc = {1'b0, cfg.row_count} + 10'd1;
        // An empty bitmap also lands on zero here, since rc_inc >= 0 always holds.
        upd.value = (rc_inc >= {1'b0, limit}) ? '0 : rc_inc[ROWS_W-1:0];
        upd.en    = 1'b1;

        job.count = 2'd0;
        job.wr    = '0;

        unique case (mode)
            MODE_W32: begin
                if (limit != '0 && px >= 14'sd0 && px <= X32_MAX && srow >= 14'sd0 &&
                    py <= Y32_MAX) begin
                    job.count   = 2'd2;
                    job.wr[0]   = '{word_addr, a_main, 1'b0, 1'b0};
                    job.wr[1]   = '{word_addr + 24'd4, a_spill, 1'b0, 1'b1};
                end
            end
            MODE_W64: begin
                if (limit != '0 && px >= 14'sd0 && px <= X64_MAX && py >= 14'sd0 &&
                    py_end <= Y64_MAX) begin
                    job.count   = 2'd3;
                    job.wr[0]   = '{word_addr, a_main, 1'b0, 1'b0};
                    job.wr[1]   = '{word_addr + 24'd4, a_spill | b_main, 1'b0, 1'b0};
                    job.wr[2]   = '{word_addr + 24'd8, b_spill, 1'b0, 1'b1};
                end
            end
            MODE_GLYPH: begin
                if (px >= 14'sd0 && px < XG_LIM && py >= 14'sd0 && py < YG_LIM) begin
                    job.count   = 2'd2;
                    job.wr[0]   = '{byte_addr, {24'd0, g_main}, 1'b1, 1'b0};
                    job.wr[1]   = '{byte_addr + 24'd1, {24'd0, g_spill}, 1'b1, 1'b1};
                end
            end
            default: begin
                // Unused mode: no writes and the row counter holds.
                upd.en = 1'b0;
            end
        endcase
    end

endmodule

[rtl/sbl_queue.sv]
// Result register bank that hands out the writes of one row, one per cycle while m_ready is high.
`include "sprite_shift_or_blitter_assert.svh"

module sbl_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  sbl_pkg::job_t      job,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output sbl_pkg::out_item_t m_item
);
    import sbl_pkg::*;

    out_item_t [MAX_WRITES-1:0] wr_reg;
    logic                       job_valid_reg;
    logic                       job_valid_next;
    logic [1:0]                 slot_reg;
    logic [1:0]                 slot_next;
    logic                       pop;
    logic                       done;

    assign m_valid  = job_valid_reg;
    assign m_item   = wr_reg[slot_reg];
    assign pop      = job_valid_reg && m_ready;
    assign done     = pop && m_item.last_write;
    assign in_ready = !job_valid_reg || done;

    always_comb begin
        job_valid_next = job_valid_reg;
        slot_next      = slot_reg;
        if (load) begin
            job_valid_next = (job.count != 2'd0);
            slot_next      = 2'd0;
        end else if (done) begin
            job_valid_next = 1'b0;
            slot_next      = 2'd0;
        end else if (pop) begin
            slot_next = slot_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            slot_reg      <= 2'd0;
        end else begin
            job_valid_reg <= job_valid_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            wr_reg <= job.wr;
        end
    end

    `SBL_ASSERT_NEXT(a_step_slot, aclk, aresetn, pop && !m_item.last_write, m_valid && slot_reg == $past(slot_reg) + 2'd1)
    `SBL_ASSERT_NEXT(a_load_start, aclk, aresetn, load && job.count != 2'd0, m_valid && slot_reg == 2'd0)
    `SBL_ASSERT_NOW(a_third_last, aclk, aresetn, m_valid && slot_reg == 2'd2, m_item.last_write)

endmodule

[rtl/sprite_shift_or_blitter.sv]
// Top level of the monochrome bitmap shift-and-OR blitter.
//
// Each item on the s_ channel is one bitmap row; the block answers on the m_
// channel with the OR-writes that draw that row into a 1-bit frame buffer at
// the configured pos_x, pos_y. A 32-wide sprite row gives two word writes, a
// 64-wide sprite row gives three, and a glyph row gives two byte writes. The
// final write of each row carries last_write. Clipped rows give no writes.
// Registers are written on the cfg_ channel (index, data); any write to a
// defined register clears the row counter. Write them only while idle.
// The first write of a row is presented the cycle after the row is accepted.
// The result channel moves one write per cycle while m_ready is high; a clipped
// row puts nothing on it. The next row is accepted in the same cycle as the
// last write of the previous row.
// If the receiver stalls, the pending write holds on m_item and s_ready stays
// low until the last write of the current row is taken.
// Reset (aresetn low, synchronous) empties the result bank, clears the row
// counter and returns the registers to base 0, position 0,0, the 32-wide mode
// and 32 rows.
module sprite_shift_or_blitter #(
    parameter int SCREEN_W  = sbl_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H  = sbl_pkg::SCREEN_H_DEF,
    parameter int ROW_BYTES = sbl_pkg::ROW_BYTES_DEF,
    parameter int SPRITE_H  = sbl_pkg::SPRITE_H_DEF,
    parameter int HITBOX_W  = sbl_pkg::HITBOX_W_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sbl_pkg::in_item_t              s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sbl_pkg::out_item_t             m_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sbl_pkg::*;

    cfg_state_t cfg_state;
    job_t       job;
    row_upd_t   upd;
    logic       item_accept;

    // Register writes never wait.
    assign cfg_ready   = 1'b1;
    assign item_accept = s_valid && s_ready;

    sbl_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item_accept (item_accept),
        .upd         (upd),
        .state       (cfg_state)
    );

    // The writes of a row are formed straight from the accepted item and the
    // current row counter, and land in the result bank at the same edge.
    sbl_calc #(
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H),
        .ROW_BYTES (ROW_BYTES),
        .SPRITE_H  (SPRITE_H),
        .HITBOX_W  (HITBOX_W)
    ) u_calc (
        .cfg  (cfg_state),
        .item (s_item),
        .job  (job),
        .upd  (upd)
    );

    sbl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (item_accept),
        .job      (job),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
